### rtl/itrr_pkg.sv
// Shared types and constants for the ISO-TP UDS response reassembler.
// Used by the front, queue, back and top-level modules; no dependencies.
package itrr_pkg;

  // Field widths.
  localparam int unsigned ID_W   = 11;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned SLOTS  = 8;

  // Service identifiers and the single-frame length mask.
  localparam logic [BYTE_W-1:0] SID_POSITIVE = 8'h62;
  localparam logic [BYTE_W-1:0] SID_NEGATIVE = 8'h7F;
  localparam logic [BYTE_W-1:0] LEN_MASK     = 8'h0F;

  // Frame types carried in the high nibble of byte0.
  localparam logic [3:0] FT_SINGLE      = 4'd0;
  localparam logic [3:0] FT_FIRST       = 4'd1;
  localparam logic [3:0] FT_CONSECUTIVE = 4'd2;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FLOW  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  // One frame's work for the back end: aligned payload bytes, a count,
  // and an optional trailing flow-control or abort result.
  typedef struct packed {
    logic [SLOTS-1:0][BYTE_W-1:0] data;
    logic [CNT_W-1:0]             count;
    logic                         msg_end;
    logic                         flow_ctl;
    logic                         abort;
  } job_t;

  // Queue geometry between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

endpackage

### rtl/isotp_uds_response_reassembler_core.sv
// ISO-TP receive reassembler for UDS ReadDataByIdentifier responses.
// Depends on itrr_pkg and the itrr_front, itrr_queue and itrr_back modules.
//
// Each accepted CAN frame yields zero to seven results, one per clock cycle
// while out_ready takes them; the back-end result sequencer is the only unit
// that sets the result rate. The front end classifies a frame in the cycle it
// is accepted and can take a new frame every cycle while the two-entry job
// queue has room; frames that cause no result are accepted but take no
// back-end time. Results pass through the job queue into an output register
// and are held there until taken.
// The expected response identifier is written over the cfg port, which is
// always ready; write it only while the block is idle.
module isotp_uds_response_reassembler_core import itrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ID_W-1:0]   in_frame_id,
  input  logic [BYTE_W-1:0] in_byte0,
  input  logic [BYTE_W-1:0] in_byte1,
  input  logic [BYTE_W-1:0] in_byte2,
  input  logic [BYTE_W-1:0] in_byte3,
  input  logic [BYTE_W-1:0] in_byte4,
  input  logic [BYTE_W-1:0] in_byte5,
  input  logic [BYTE_W-1:0] in_byte6,
  input  logic [BYTE_W-1:0] in_byte7,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic              out_message_end,
  output logic              out_run_last
);

  logic [ID_W-1:0] response_id_r;
  logic            q_ready, push, pop, head_valid;
  job_t            push_job, head_job;

  // Response identifier register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      response_id_r <= '0;
    end else if (cfg_valid) begin
      response_id_r <= cfg_data;
    end
  end

  itrr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .response_id (response_id_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_frame_id (in_frame_id),
    .in_byte0    (in_byte0),
    .in_byte1    (in_byte1),
    .in_byte2    (in_byte2),
    .in_byte3    (in_byte3),
    .in_byte4    (in_byte4),
    .in_byte5    (in_byte5),
    .in_byte6    (in_byte6),
    .in_byte7    (in_byte7),
    .q_ready     (q_ready),
    .push        (push),
    .job         (push_job)
  );

  itrr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  itrr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_message_end (out_message_end),
    .out_run_last    (out_run_last)
  );

endmodule

### rtl/itrr_front.sv
// Front end: accepts CAN frames, tracks reassembly state, builds jobs.
// Depends on itrr_pkg; feeds itrr_queue.
module itrr_front import itrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ID_W-1:0]   response_id,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ID_W-1:0]   in_frame_id,
  input  logic [BYTE_W-1:0] in_byte0,
  input  logic [BYTE_W-1:0] in_byte1,
  input  logic [BYTE_W-1:0] in_byte2,
  input  logic [BYTE_W-1:0] in_byte3,
  input  logic [BYTE_W-1:0] in_byte4,
  input  logic [BYTE_W-1:0] in_byte5,
  input  logic [BYTE_W-1:0] in_byte6,
  input  logic [BYTE_W-1:0] in_byte7,
  input  logic              q_ready,
  output logic              push,
  output job_t              job
);

  logic              multi_r, multi_nxt;
  logic [BYTE_W-1:0] rem_r, rem_nxt;

  logic              accept;
  logic              job_some;
  logic [3:0]        ftype;
  logic [BYTE_W-1:0] sf_len;
  logic [CNT_W-1:0]  sf_total, sf_n;
  logic [BYTE_W-1:0] ff_payload, ff_rem;
  logic [CNT_W-1:0]  ff_n;
  logic [CNT_W-1:0]  cf_n;
  logic [BYTE_W-1:0] cf_rem;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign ftype    = in_byte0[7:4];

  // Counts for each frame type.
  assign sf_len     = in_byte0 & LEN_MASK;
  assign sf_total   = (sf_len > 8'd7) ? 3'd7 : sf_len[CNT_W-1:0];
  assign sf_n       = (sf_total > 3'd3) ? sf_total - 3'd3 : 3'd0;
  assign ff_payload = (in_byte1 > 8'd3) ? in_byte1 - 8'd3 : 8'd0;
  assign ff_n       = (ff_payload < 8'd3) ? ff_payload[CNT_W-1:0] : 3'd3;
  assign ff_rem     = ff_payload - {5'd0, ff_n};
  assign cf_n       = (rem_r < 8'd7) ? rem_r[CNT_W-1:0] : 3'd7;
  assign cf_rem     = rem_r - {5'd0, cf_n};

  // Classify the frame into a job and the next reassembly state.
  always_comb begin
    job       = '0;
    job_some  = 1'b0;
    multi_nxt = multi_r;
    rem_nxt   = rem_r;
    priority if (in_frame_id != response_id) begin
      job.abort = 1'b1;
      job_some  = 1'b1;
      multi_nxt = 1'b0;
      rem_nxt   = '0;
    end else if (ftype == FT_SINGLE) begin
      if (in_byte1 == SID_POSITIVE && in_byte1 != SID_NEGATIVE) begin
        job.data    = {32'd0, in_byte7, in_byte6, in_byte5, in_byte4};
        job.count   = sf_n;
        job.msg_end = 1'b1;
        job_some    = (sf_n != '0);
        multi_nxt   = 1'b0;
        rem_nxt     = '0;
      end
    end else if (ftype == FT_FIRST) begin
      job.data     = {40'd0, in_byte7, in_byte6, in_byte5};
      job.count    = ff_n;
      job.msg_end  = (ff_rem == '0);
      job.flow_ctl = (ff_rem != '0);
      job_some     = (ff_n != '0) || (ff_rem != '0);
      multi_nxt    = (ff_rem != '0);
      rem_nxt      = ff_rem;
    end else if (ftype == FT_CONSECUTIVE) begin
      if (multi_r) begin
        job.data    = {8'd0, in_byte7, in_byte6, in_byte5, in_byte4,
                       in_byte3, in_byte2, in_byte1};
        job.count   = cf_n;
        job.msg_end = (cf_rem == '0);
        job_some    = (cf_n != '0);
        multi_nxt   = (cf_rem != '0);
        rem_nxt     = cf_rem;
      end
    end else begin
      job_some = 1'b0;
    end
  end

  assign push = accept && job_some;

  // Reassembly state advances on every accepted frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      multi_r <= 1'b0;
      rem_r   <= '0;
    end else if (accept) begin
      multi_r <= multi_nxt;
      rem_r   <= rem_nxt;
    end
  end

`ifndef SYNTH
  // Multi-frame mode is on exactly while bytes are still owed.
  a_multi_matches_rem: assert property (@(posedge clk) disable iff (!rst_n)
    multi_r == (rem_r != '0))
    else $error("multi-frame flag disagrees with remaining byte count");
`endif

endmodule

### rtl/itrr_queue.sv
// Two-entry job queue decoupling the front end from the back end.
// Depends on itrr_pkg for job_t and the queue geometry.
module itrr_queue import itrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic q_ready,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t            entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign q_ready    = (count_r != Q_DEPTH[Q_AW:0]);
  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];
  assign do_push    = push && q_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_DEPTH[Q_AW:0])
    else $error("job queue count exceeds its depth");
`endif

endmodule

### rtl/itrr_back.sv
// Back end: walks the head job one result per cycle, unless out_ready stalls,
// into an output register. Depends on itrr_pkg; reads jobs from itrr_queue.
module itrr_back import itrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  job_t              head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic              out_message_end,
  output logic              out_run_last
);

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r;
  logic [BYTE_W-1:0] data_r;
  logic              end_r, last_r;

  logic              advance;
  logic              is_data, last_data, has_tail, is_final;
  kind_t             cur_kind;
  logic [BYTE_W-1:0] cur_data;
  logic              cur_end;

  assign advance   = head_valid && (!out_valid_r || out_ready);
  assign is_data   = idx_r < head_job.count;
  assign last_data = (idx_r == head_job.count - 3'd1);
  assign has_tail  = head_job.flow_ctl || head_job.abort;
  assign is_final  = is_data ? (last_data && !has_tail) : 1'b1;
  assign pop       = advance && is_final;

  // Result for the current position in the head job.
  always_comb begin
    cur_kind = KIND_DATA;
    cur_data = '0;
    cur_end  = 1'b0;
    priority if (is_data) begin
      cur_data = head_job.data[idx_r];
      cur_end  = last_data && head_job.msg_end;
    end else if (head_job.abort) begin
      cur_kind = KIND_ABORT;
    end else begin
      cur_kind = KIND_FLOW;
    end
  end

  // Position and output-valid next values.
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      idx_nxt       = is_final ? '0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register, loaded on each transfer into it.
  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= cur_kind;
      data_r <= cur_data;
      end_r  <= cur_end;
      last_r <= is_final;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_data_byte   = data_r;
  assign out_message_end = end_r;
  assign out_run_last    = last_r;

`ifndef SYNTH
  // The position never runs past the head job's data bytes.
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r <= head_job.count)
    else $error("result position past the end of the job");

  // The end of a message is always a data byte closing its frame.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && end_r) |-> (last_r && kind_r == KIND_DATA))
    else $error("message end on a result that does not close its frame");

  // A job is only released on its final result.
  a_pop_final: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && last_r))
    else $error("job released without its final result");
`endif

endmodule
